@@ hdl/frds_pkg.sv @@
`timescale 1ns / 1ps

package frds_pkg;

  // defaults for the top level parameters
  localparam int DEF_NUM_BANKS   = 16;
  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_ROW_BITS    = 16;
  localparam int DEF_TAG_BITS    = 8;

  // fixed field widths
  localparam int BANK_W     = 4;
  localparam int BANK_EXT_W = 7;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 3;

  // command kinds
  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_SCHED = 1'b1
  } req_kind_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPLIT  = 3'd0,
    REG_HIGH   = 3'd1,
    REG_LOW    = 3'd2,
    REG_RD_LIM = 3'd3,
    REG_WR_LIM = 3'd4
  } reg_idx_e;

  // control from the sequencer to the scan unit
  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

endpackage

@@ hdl/frds_ram.sv @@
`timescale 1ns / 1ps

module frds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/frds_scan.sv @@
`timescale 1ns / 1ps

module frds_scan import frds_pkg::*; #(
  parameter int ROW_BITS = DEF_ROW_BITS,
  parameter int TAG_BITS = DEF_TAG_BITS,
  parameter int SW       = 7,
  parameter int AW       = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scan_ctl_t           ctl_i,
  input  logic                q_i,
  input  logic [BANK_W-1:0]   bank_i,
  input  logic [ROW_BITS-1:0] tgt_row_i,
  input  logic                valid_i,
  input  logic [SW-1:0]       slot_i,
  input  logic [BANK_W-1:0]   e_bank_i,
  input  logic [ROW_BITS-1:0] e_row_i,
  input  logic [TAG_BITS-1:0] e_tag_i,
  input  logic                e_isw_i,
  input  logic                e_inwq_i,
  input  logic [AW-1:0]       e_arr_i,
  output logic                m_found_o,
  output logic                m_multi_o,
  output logic [SW-1:0]       m_slot_o,
  output logic [AW-1:0]       m_arr_o,
  output logic [ROW_BITS-1:0] m_row_o,
  output logic [TAG_BITS-1:0] m_tag_o,
  output logic                m_isw_o,
  output logic                a_found_o,
  output logic [ROW_BITS-1:0] a_row_o
);

  logic          bank_hit, row_hit;
  logic [AW-1:0] a_arr_q;

  assign bank_hit = valid_i && (e_inwq_i == q_i) && (e_bank_i == bank_i);
  assign row_hit  = bank_hit && (e_row_i == tgt_row_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_found_o <= 1'b0;
      m_multi_o <= 1'b0;
      a_found_o <= 1'b0;
    end else if (ctl_i.clear) begin
      m_found_o <= 1'b0;
      m_multi_o <= 1'b0;
      a_found_o <= 1'b0;
    end else if (ctl_i.sample) begin
      if (row_hit) begin
        if (m_found_o) begin
          m_multi_o <= 1'b1;
        end
        if (!m_found_o || (e_arr_i < m_arr_o)) begin
          m_found_o <= 1'b1;
          m_slot_o  <= slot_i;
          m_arr_o   <= e_arr_i;
          m_row_o   <= e_row_i;
          m_tag_o   <= e_tag_i;
          m_isw_o   <= e_isw_i;
        end
      end
      if (bank_hit && (!a_found_o || (e_arr_i < a_arr_q))) begin
        a_found_o <= 1'b1;
        a_arr_q   <= e_arr_i;
        a_row_o   <= e_row_i;
      end
    end
  end

endmodule

@@ hdl/frfcfs_dram_request_scheduler.sv @@
`timescale 1ns / 1ps

// FR-FCFS DRAM request scheduler with optional write queue and drain watermarks.
// Command channel: an item is taken at a clock edge with start high and busy low.
//   req_type_i 0 adds a request (bank, row, write flag, tag), 1 schedules one bank
//   given the row open in it. busy stays high until the item is finished.
// Result channel: done_o is high for exactly one cycle per item with all result
//   fields; there is no back pressure, the receiver must take it then.
// Config port: cfg_we_i/cfg_idx_i/cfg_data_i write one register per cycle; the user
//   writes only while busy is low, the block itself does not enforce it.
// Sequencing: an add walks the valid bits one slot a cycle to find a free slot. A
//   schedule scans all 2*QUEUE_DEPTH slots of the request memory through one
//   compare unit, then decides; a miss needs a second pass. After a grant the memory
//   is swept once more to renumber arrival ranks while the result is already out,
//   and busy stays high through the sweep; a bank out of range is answered without
//   a scan. One item at a time; the single read port of the memory makes the walks
//   go slot by slot.
// Reset: all slots invalid, all rows unlocked, counts zero, read mode; no
//   clearing pass is needed since slot data is only read behind a valid bit.
module frfcfs_dram_request_scheduler import frds_pkg::*; #(
  parameter int NUM_BANKS   = DEF_NUM_BANKS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int ROW_BITS    = DEF_ROW_BITS,
  parameter int TAG_BITS    = DEF_TAG_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type_i,
  input  logic [BANK_W-1:0]    bank_i,
  input  logic [ROW_BITS-1:0]  row_i,
  input  logic                 wr_req_i,
  input  logic [TAG_BITS-1:0]  req_tag_i,
  input  logic [ROW_BITS-1:0]  open_row_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 done_o,
  output logic                 accepted_o,
  output logic                 queue_full_o,
  output logic                 granted_o,
  output logic [TAG_BITS-1:0]  grant_tag_o,
  output logic [ROW_BITS-1:0]  grant_row_o,
  output logic                 grant_wr_o,
  output logic                 row_hit_o,
  output logic                 in_write_mode_o
);

  localparam int SLOT_COUNT = 2 * QUEUE_DEPTH;
  localparam int SW   = $clog2(SLOT_COUNT);
  localparam int AW   = SW;
  localparam int SCW  = $clog2(SLOT_COUNT + 1);
  localparam int PW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW = (PW > CFG_W) ? PW : CFG_W;
  localparam int BIW  = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  // request word layout: {arrival, in write queue, is write, tag, row, bank}
  localparam int ROW_LSB  = BANK_W;
  localparam int TAG_LSB  = ROW_LSB + ROW_BITS;
  localparam int ISW_BIT  = TAG_LSB + TAG_BITS;
  localparam int INWQ_BIT = ISW_BIT + 1;
  localparam int ARR_LSB  = INWQ_BIT + 1;
  localparam int EW       = ARR_LSB + AW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_FIND,
    ST_SCAN,
    ST_DECIDE,
    ST_SWEEP
  } state_e;

  state_e state_q;

  // configuration
  logic             split_q;
  logic [CFG_W-1:0] high_q, low_q, rd_lim_q, wr_lim_q;

  // queue state
  logic [SLOT_COUNT-1:0] valid_q;
  logic [SCW-1:0]        arr_cnt_q;
  logic [PW-1:0]         reads_q, writes_q;
  logic                  write_mode_q;
  logic                  lk_locked_q [2][NUM_BANKS];
  logic [ROW_BITS-1:0]   lk_row_q    [2][NUM_BANKS];

  // item held for the sequence
  logic [BANK_W-1:0]   bank_q;
  logic [BIW-1:0]      bidx_q;
  logic [ROW_BITS-1:0] row_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                isw_q;
  logic                q_q;
  logic [ROW_BITS-1:0] tgt_q;
  logic                was_locked_q;
  logic                pass_b_q;
  logic [SCW-1:0]      cnt_q;
  logic [SW-1:0]       rd_idx_q;
  logic [SW-1:0]       fidx_q;
  logic [AW-1:0]       rem_arr_q;

  // accept-time decode
  logic [BANK_EXT_W-1:0] bank_ext;
  logic                  bank_ok;
  logic [BIW-1:0]        bidx;
  logic                  add_wq;
  logic [CMPW-1:0]       add_lim, add_cnt, wr_cnt_ext;
  logic                  write_mode_d;

  // memory and scan signals
  logic             ram_we;
  logic [SW-1:0]    ram_waddr;
  logic [EW-1:0]    ram_wdata, ram_rdata;
  logic [AW-1:0]    e_arr;
  logic             e_valid;
  logic             sweep_dec;
  scan_ctl_t        scan_ctl;
  logic             m_found, m_multi, m_isw, a_found;
  logic [SW-1:0]    m_slot;
  logic [AW-1:0]    m_arr;
  logic [ROW_BITS-1:0] m_row, a_row;
  logic [TAG_BITS-1:0] m_tag;

  assign busy = (state_q != ST_IDLE);

  assign bank_ext = BANK_EXT_W'(bank_i);
  assign bank_ok  = (bank_ext < BANK_EXT_W'(NUM_BANKS));
  assign bidx     = bank_ext[BIW-1:0];
  assign add_wq   = split_q && wr_req_i;

  // limit above the queue depth acts as the depth
  always_comb begin
    add_lim = add_wq ? CMPW'(wr_lim_q) : CMPW'(rd_lim_q);
    if (add_lim > CMPW'(QUEUE_DEPTH)) begin
      add_lim = CMPW'(QUEUE_DEPTH);
    end
    add_cnt    = add_wq ? CMPW'(writes_q) : CMPW'(reads_q);
    wr_cnt_ext = CMPW'(writes_q);
  end

  // watermark hysteresis, only while the write split is on
  always_comb begin
    write_mode_d = write_mode_q;
    if (split_q) begin
      if (!write_mode_q && (wr_cnt_ext >= CMPW'(high_q))) begin
        write_mode_d = 1'b1;
      end else if (write_mode_q && (wr_cnt_ext < CMPW'(low_q))) begin
        write_mode_d = 1'b0;
      end
    end
  end

  // request memory: free-slot write on add, arrival renumbering on sweep
  assign e_arr     = ram_rdata[ARR_LSB +: AW];
  assign e_valid   = valid_q[rd_idx_q];
  assign sweep_dec = (state_q == ST_SWEEP) && (cnt_q != '0) && e_valid &&
                     (e_arr > rem_arr_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fidx_q;
    ram_wdata = {arr_cnt_q[AW-1:0], q_q, isw_q, tag_q, row_q, bank_q};
    if ((state_q == ST_ADD_FIND) && !valid_q[fidx_q]) begin
      ram_we = 1'b1;
    end else if (sweep_dec) begin
      ram_we    = 1'b1;
      ram_waddr = rd_idx_q;
      ram_wdata = {e_arr - AW'(1), ram_rdata[ARR_LSB-1:0]};
    end
  end

  frds_ram #(
    .WIDTH (EW),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[SW-1:0]),
    .rdata_o (ram_rdata)
  );

  // the scan takes one slot a cycle, data arrives in the cycle after its address
  assign scan_ctl.clear  = (state_q == ST_SCAN) && (cnt_q == '0);
  assign scan_ctl.sample = (state_q == ST_SCAN) && (cnt_q != '0);

  frds_scan #(
    .ROW_BITS (ROW_BITS),
    .TAG_BITS (TAG_BITS),
    .SW       (SW),
    .AW       (AW)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .q_i       (q_q),
    .bank_i    (bank_q),
    .tgt_row_i (tgt_q),
    .valid_i   (e_valid),
    .slot_i    (rd_idx_q),
    .e_bank_i  (ram_rdata[BANK_W-1:0]),
    .e_row_i   (ram_rdata[ROW_LSB +: ROW_BITS]),
    .e_tag_i   (ram_rdata[TAG_LSB +: TAG_BITS]),
    .e_isw_i   (ram_rdata[ISW_BIT]),
    .e_inwq_i  (ram_rdata[INWQ_BIT]),
    .e_arr_i   (e_arr),
    .m_found_o (m_found),
    .m_multi_o (m_multi),
    .m_slot_o  (m_slot),
    .m_arr_o   (m_arr),
    .m_row_o   (m_row),
    .m_tag_o   (m_tag),
    .m_isw_o   (m_isw),
    .a_found_o (a_found),
    .a_row_o   (a_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      split_q          <= 1'b0;
      high_q           <= CFG_W'(32);
      low_q            <= CFG_W'(16);
      rd_lim_q         <= CFG_W'(64);
      wr_lim_q         <= CFG_W'(64);
      valid_q          <= '0;
      arr_cnt_q        <= '0;
      reads_q          <= '0;
      writes_q         <= '0;
      write_mode_q     <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        for (int b = 0; b < NUM_BANKS; b++) begin
          lk_locked_q[i][b] <= 1'b0;
        end
      end
      cnt_q            <= '0;
      rd_idx_q         <= '0;
      done_o           <= 1'b0;
      accepted_o       <= 1'b0;
      queue_full_o     <= 1'b0;
      granted_o        <= 1'b0;
      grant_tag_o      <= '0;
      grant_row_o      <= '0;
      grant_wr_o       <= 1'b0;
      row_hit_o        <= 1'b0;
      in_write_mode_o  <= 1'b0;
    end else begin
      done_o   <= 1'b0;
      rd_idx_q <= cnt_q[SW-1:0];

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SPLIT:  split_q  <= cfg_data_i[0];
          REG_HIGH:   high_q   <= cfg_data_i;
          REG_LOW:    low_q    <= cfg_data_i;
          REG_RD_LIM: rd_lim_q <= cfg_data_i;
          REG_WR_LIM: wr_lim_q <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (start) begin
            bank_q <= bank_i;
            bidx_q <= bidx;
            row_q  <= row_i;
            tag_q  <= req_tag_i;
            isw_q  <= wr_req_i;
            accepted_o       <= 1'b0;
            queue_full_o     <= 1'b0;
            granted_o        <= 1'b0;
            grant_tag_o      <= '0;
            grant_row_o      <= '0;
            grant_wr_o       <= 1'b0;
            row_hit_o        <= 1'b0;
            if (req_type_i == REQ_ADD) begin
              q_q             <= add_wq;
              in_write_mode_o <= write_mode_q;
              if (!bank_ok) begin
                done_o <= 1'b1;
              end else if (add_cnt < add_lim) begin
                fidx_q  <= '0;
                state_q <= ST_ADD_FIND;
              end else begin
                queue_full_o <= 1'b1;
                done_o       <= 1'b1;
              end
            end else begin
              write_mode_q    <= write_mode_d;
              in_write_mode_o <= write_mode_d;
              q_q             <= write_mode_d;
              if (!bank_ok) begin
                done_o <= 1'b1;
              end else begin
                // locked row continues, else try the open row first
                was_locked_q <= lk_locked_q[write_mode_d][bidx];
                tgt_q        <= lk_locked_q[write_mode_d][bidx]
                                ? lk_row_q[write_mode_d][bidx] : open_row_i;
                pass_b_q     <= 1'b0;
                cnt_q        <= '0;
                state_q      <= ST_SCAN;
              end
            end
          end
        end

        ST_ADD_FIND: begin
          // a free slot exists since each queue holds at most the depth
          if (!valid_q[fidx_q]) begin
            valid_q[fidx_q] <= 1'b1;
            arr_cnt_q       <= arr_cnt_q + SCW'(1);
            if (q_q) begin
              writes_q <= writes_q + PW'(1);
            end else begin
              reads_q <= reads_q + PW'(1);
            end
            accepted_o <= 1'b1;
            done_o     <= 1'b1;
            state_q    <= ST_IDLE;
          end else begin
            fidx_q <= fidx_q + SW'(1);
          end
        end

        ST_SCAN: begin
          cnt_q <= cnt_q + SCW'(1);
          if (cnt_q == SCW'(SLOT_COUNT)) begin
            state_q <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          cnt_q <= '0;
          if (!pass_b_q && !m_found && (was_locked_q || !a_found)) begin
            // nothing to grant; a stale lock is dropped
            lk_locked_q[q_q][bidx_q] <= 1'b0;
            done_o  <= 1'b1;
            state_q <= ST_IDLE;
          end else if (!pass_b_q && !m_found) begin
            // miss: second pass on the row of the oldest request of the bank
            tgt_q    <= a_row;
            pass_b_q <= 1'b1;
            state_q  <= ST_SCAN;
          end else begin
            lk_row_q[q_q][bidx_q]    <= tgt_q;
            lk_locked_q[q_q][bidx_q] <= m_multi;
            valid_q[m_slot]  <= 1'b0;
            arr_cnt_q        <= arr_cnt_q - SCW'(1);
            if (q_q) begin
              if (writes_q != '0) begin
                writes_q <= writes_q - PW'(1);
              end
            end else if (reads_q != '0) begin
              reads_q <= reads_q - PW'(1);
            end
            rem_arr_q        <= m_arr;
            granted_o        <= 1'b1;
            grant_tag_o      <= m_tag;
            grant_row_o      <= m_row;
            grant_wr_o       <= m_isw;
            row_hit_o        <= !pass_b_q;
            done_o           <= 1'b1;
            state_q          <= ST_SWEEP;
          end
        end

        ST_SWEEP: begin
          cnt_q <= cnt_q + SCW'(1);
          if (cnt_q == SCW'(SLOT_COUNT)) begin
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // assertions

  a_acc_full_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(accepted_o && queue_full_o))
    else $error("add reported both stored and full");

  a_grant_vs_add : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && granted_o |-> !accepted_o && !queue_full_o)
    else $error("grant mixed with add result");

  a_pending_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (reads_q <= PW'(QUEUE_DEPTH)) && (writes_q <= PW'(QUEUE_DEPTH)))
    else $error("pending count above queue depth");

  a_sweep_after_grant : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) && (cnt_q == '0) |-> granted_o && done_o)
    else $error("renumbering sweep without a grant");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench import frds_pkg::*; ();

  localparam int BANKS    = DEF_NUM_BANKS;
  localparam int DEPTH    = DEF_QUEUE_DEPTH;
  localparam int RW       = DEF_ROW_BITS;
  localparam int TW       = DEF_TAG_BITS;
  localparam int SLOTS    = 2 * DEPTH;
  localparam int STALL_MAX = 4000;   // well above one schedule at full depth
  localparam int TAIL_CYC  = 500;

  typedef struct packed {
    logic          accepted;
    logic          full;
    logic          granted;
    logic [TW-1:0] tag;
    logic [RW-1:0] row;
    logic          gnt_wr;
    logic          hit;
    logic          wmode;
  } sched_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic req_type_i = 1'b0;
  logic [BANK_W-1:0] bank_i = '0;
  logic [RW-1:0] row_i = '0;
  logic wr_req_i = 1'b0;
  logic [TW-1:0] req_tag_i = '0;
  logic [RW-1:0] open_row_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic done_o, accepted_o, queue_full_o, granted_o, grant_wr_o, row_hit_o;
  logic in_write_mode_o;
  logic [TW-1:0] grant_tag_o;
  logic [RW-1:0] grant_row_o;

  frfcfs_dram_request_scheduler dut (.*);

  initial forever #1 clk_i = ~clk_i;

  // scheduler shadow state
  logic          sh_split;
  logic [6:0]    sh_high, sh_low, sh_rd_lim, sh_wr_lim;
  logic          sl_vld [SLOTS];
  logic [3:0]    sl_bank [SLOTS];
  logic [RW-1:0] sl_row [SLOTS];
  logic [TW-1:0] sl_tag [SLOTS];
  logic          sl_isw [SLOTS];
  logic          sl_wq [SLOTS];
  int            sl_rank [SLOTS];
  int            rank_next;
  logic          lk_on [2][BANKS];
  logic [RW-1:0] lk_row [2][BANKS];
  int            pend [2];
  logic          wmode;

  sched_result_t expected_results[$];
  int  errors = 0;
  int  n_items = 0, n_grants = 0, n_hits = 0, n_full = 0, n_wmode = 0;
  bit  idle_ok = 1'b1;
  int  stall_cnt = 0;

  function automatic int oldest(logic q, logic [3:0] b, bit match, logic [RW-1:0] r);
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (sl_vld[i] && sl_wq[i] == q && sl_bank[i] == b && (!match || sl_row[i] == r))
        if (best < 0 || sl_rank[i] < sl_rank[best]) best = i;
    end
    return best;
  endfunction

  task automatic predict_result(input req_kind_e kind, input logic [3:0] b,
                                input logic [RW-1:0] r, input logic w,
                                input logic [TW-1:0] t, input logic [RW-1:0] open,
                                output sched_result_t res);
    logic q;
    int lim, s, g;
    bit ok;
    res = '0;
    if (kind == REQ_ADD) begin
      q = sh_split && w;
      lim = q ? sh_wr_lim : sh_rd_lim;
      if (lim > DEPTH) lim = DEPTH;
      s = -1;
      if (pend[q] < lim)
        for (int i = 0; i < SLOTS && s < 0; i++) if (!sl_vld[i]) s = i;
      if (s < 0) begin
        res.full = 1'b1;
      end else begin
        sl_vld[s] = 1'b1; sl_bank[s] = b; sl_row[s] = r; sl_tag[s] = t;
        sl_isw[s] = w; sl_wq[s] = q; sl_rank[s] = rank_next++;
        pend[q]++;
        res.accepted = 1'b1;
      end
    end else begin
      // watermark mode switch only while the split is on
      if (sh_split) begin
        if (!wmode && pend[1] >= sh_high) wmode = 1'b1;
        else if (wmode && pend[1] < sh_low) wmode = 1'b0;
      end
      q = wmode;
      ok = 1'b1;
      res.hit = 1'b1;
      if (!lk_on[q][b]) begin
        s = oldest(q, b, 1'b1, open);
        if (s >= 0) lk_row[q][b] = open;
        else begin
          s = oldest(q, b, 1'b0, '0);
          if (s < 0) ok = 1'b0;
          else begin
            lk_row[q][b] = sl_row[s];
            res.hit = 1'b0;
          end
        end
        if (ok) lk_on[q][b] = 1'b1;
      end
      if (ok) begin
        g = oldest(q, b, 1'b1, lk_row[q][b]);
        if (g < 0) begin
          lk_on[q][b] = 1'b0;
          ok = 1'b0;
        end else begin
          res.granted = 1'b1; res.tag = sl_tag[g]; res.row = sl_row[g];
          res.gnt_wr = sl_isw[g];
          // close the gap in arrival ranks
          sl_vld[g] = 1'b0;
          for (int i = 0; i < SLOTS; i++)
            if (sl_vld[i] && sl_rank[i] > sl_rank[g]) sl_rank[i]--;
          if (rank_next > 0) rank_next--;
          if (pend[q] > 0) pend[q]--;
          if (oldest(q, b, 1'b1, lk_row[q][b]) < 0) lk_on[q][b] = 1'b0;
        end
      end
      if (!ok) res.hit = 1'b0;
    end
    res.wmode = wmode;
  endtask

  // one command transfer; start stays high so back-to-back items need no toggle
  task automatic send_item(input req_kind_e kind, input logic [3:0] b,
                           input logic [RW-1:0] r, input logic w,
                           input logic [TW-1:0] t, input logic [RW-1:0] open);
    sched_result_t res;
    if (idle_ok && $urandom_range(0, 99) < 34) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_type_i <= kind; bank_i <= b; row_i <= r; wr_req_i <= w;
    req_tag_i <= t; open_row_i <= open;
    do @(posedge clk_i); while (busy);
    predict_result(kind, b, r, w, t, open, res);
    expected_results.push_back(res);
    n_items++;
  endtask

  // wait until nothing is in flight
  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] val);
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SPLIT:  sh_split  = val[0];
      REG_HIGH:   sh_high   = val;
      REG_LOW:    sh_low    = val;
      REG_RD_LIM: sh_rd_lim = val;
      REG_WR_LIM: sh_wr_lim = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic split, input logic [6:0] hi, input logic [6:0] lo,
                          input logic [6:0] rl, input logic [6:0] wl);
    write_reg(REG_SPLIT, {6'd0, split});
    write_reg(REG_HIGH, hi);
    write_reg(REG_LOW, lo);
    write_reg(REG_RD_LIM, rl);
    write_reg(REG_WR_LIM, wl);
  endtask

  task automatic add(input logic [3:0] b, input logic [RW-1:0] r, input logic w,
                     input logic [TW-1:0] t);
    send_item(REQ_ADD, b, r, w, t, RW'($urandom));
  endtask

  task automatic sched(input logic [3:0] b, input logic [RW-1:0] open);
    send_item(REQ_SCHED, b, RW'($urandom), 1'($urandom), TW'($urandom), open);
  endtask

  // open row hit, oldest miss, locked continuation, empty bank, field extremes
  task automatic test_hit_miss;
    add(4'd0, 16'h0001, 1'b0, 8'h00);
    add(4'd0, 16'h0002, 1'b1, 8'h11);
    add(4'd0, 16'h0001, 1'b0, 8'h22);
    sched(4'd0, 16'h0002);
    sched(4'd0, 16'h7777);
    sched(4'd0, 16'h0002);
    sched(4'd0, 16'h0001);
    add(4'd15, 16'hffff, 1'b1, 8'hff);
    sched(4'd15, 16'h0000);
    sched(4'd15, 16'hffff);
  endtask

  // limits of zero, one and above the depth
  task automatic test_queue_limit;
    set_regs(1'b0, 7'd32, 7'd16, 7'd0, 7'd64);
    add(4'd3, 16'h1234, 1'b0, 8'h01);
    write_reg(REG_RD_LIM, 7'd1);
    add(4'd3, 16'h1234, 1'b0, 8'h02);
    add(4'd3, 16'h1234, 1'b1, 8'h03);
    sched(4'd3, 16'h1234);
    write_reg(REG_RD_LIM, 7'd127);
  endtask

  // watermark drain, then split turned off while in write mode
  task automatic test_write_drain;
    set_regs(1'b1, 7'd2, 7'd1, 7'd64, 7'd0);
    add(4'd5, 16'h00aa, 1'b1, 8'h40);
    write_reg(REG_WR_LIM, 7'd127);
    add(4'd5, 16'h00aa, 1'b1, 8'h41);
    add(4'd5, 16'h00bb, 1'b1, 8'h42);
    add(4'd5, 16'h00cc, 1'b0, 8'h43);
    sched(4'd5, 16'h00bb);
    write_reg(REG_SPLIT, 7'd0);
    sched(4'd5, 16'h0000);
    sched(4'd5, 16'h0000);
    sched(4'd5, 16'h00cc);
  endtask

  // mostly a few banks and rows so rows stay locked and hit; some full-range noise
  task automatic test_random(input int count, input bit pause_midway);
    logic [RW-1:0] r, o;
    logic [3:0] b;
    for (int k = 0; k < count; k++) begin
      if (pause_midway && k == count / 2) drain();
      b = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom);
      r = ($urandom_range(0, 9) < 8) ? RW'($urandom_range(0, 3)) : RW'($urandom);
      o = ($urandom_range(0, 9) < 7) ? RW'($urandom_range(0, 3)) : RW'($urandom);
      if ($urandom_range(0, 99) < 55) add(b, r, 1'($urandom), TW'($urandom));
      else sched(b, o);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    sched_result_t got, exp_r;
    if (rst_ni && done_o) begin
      got = '{accepted_o, queue_full_o, granted_o, grant_tag_o, grant_row_o,
              grant_wr_o, row_hit_o, in_write_mode_o};
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch at %0t (exp/got): acc %b/%b full %b/%b gnt %b/%b tag %h/%h",
                     $realtime, exp_r.accepted, got.accepted, exp_r.full, got.full,
                     exp_r.granted, got.granted, exp_r.tag, got.tag);
            $display("  row %h/%h wr %b/%b hit %b/%b mode %b/%b",
                     exp_r.row, got.row, exp_r.gnt_wr, got.gnt_wr, exp_r.hit, got.hit,
                     exp_r.wmode, got.wmode);
          end
        end
        n_grants += exp_r.granted;
        n_hits += exp_r.hit;
        n_full += exp_r.full;
        n_wmode += exp_r.wmode;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    sh_split = 1'b0; sh_high = 7'd32; sh_low = 7'd16; sh_rd_lim = 7'd64; sh_wr_lim = 7'd64;
    rank_next = 0; wmode = 1'b0; pend[0] = 0; pend[1] = 0;
    for (int i = 0; i < SLOTS; i++) sl_vld[i] = 1'b0;
    for (int i = 0; i < BANKS; i++) begin
      lk_on[0][i] = 1'b0; lk_on[1][i] = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_hit_miss();
    test_queue_limit();
    test_write_drain();
    // random phases across register settings, extremes included
    set_regs(1'b0, 7'd32, 7'd16, 7'd64, 7'd64);
    test_random(175, 1'b1);
    set_regs(1'b1, 7'd8, 7'd4, 7'd64, 7'd64);
    idle_ok = 1'b0;
    test_random(175, 1'b0);
    idle_ok = 1'b1;
    set_regs(1'b1, 7'd0, 7'd0, 7'd127, 7'd127);
    test_random(175, 1'b0);
    set_regs(1'b1, 7'd127, 7'd127, 7'd64, 7'd64);
    test_random(175, 1'b0);
    set_regs(1'b1, 7'd12, 7'd64, 7'd6, 7'd5);
    test_random(175, 1'b0);
    write_reg(REG_SPLIT, 7'd0);
    test_random(175, 1'b0);
    drain();
    repeat (TAIL_CYC) @(posedge clk_i);
    $display("items %0d: %0d grants, %0d row hits, %0d rejected full, %0d in write mode",
             n_items, n_grants, n_hits, n_full, n_wmode);
    $display("mismatches %0d", errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
